### hdl/ahs_pkg.sv
`default_nettype none

package ahs_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FAST_PERIOD    = 2'd0;
   localparam logic [1:0] CSR_BACKOFF_PERIOD = 2'd1;
   localparam logic [1:0] CSR_SLOW_PERIOD    = 2'd2;
   localparam logic [1:0] CSR_HUNT_LIMIT     = 2'd3;

   localparam logic [15:0] FAST_PERIOD_RST    = 16'd127;
   localparam logic [15:0] BACKOFF_PERIOD_RST = 16'd1270;
   localparam logic [15:0] SLOW_PERIOD_RST    = 16'd2540;
   localparam logic [15:0] HUNT_LIMIT_RST     = 16'd787;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_FAST = 3'd1,
      PH_BACK = 3'd2,
      PH_SLOW = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic       switch_sample;
      logic [3:0] bin_index;
   } req_type;

   typedef struct packed {
      logic        step_pulse;
      logic        direction;
      logic [2:0]  phase;
      logic        homed_ok;
      logic [15:0] steps_fast;
      logic [15:0] steps_backoff;
      logic [15:0] steps_slow;
      logic [15:0] bin_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] fast_period;
      logic [15:0] backoff_period;
      logic [15:0] slow_period;
      logic [15:0] hunt_limit;
   } cfg_type;

   // one finished majority vote, counted in the histogram
   typedef struct packed {
      logic       valid;
      logic [3:0] total;
   } vote_type;

endpackage

`default_nettype wire

### hdl/ahs_histogram.sv
`default_nettype none

module ahs_histogram #(
   parameter int VOTE_SAMPLES = 10,
   parameter int COUNT_WIDTH  = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire ahs_pkg::vote_type vote,
   input  wire logic [3:0]        rd_bin,
   output logic [15:0]            rd_count
);

   localparam int NBINS = VOTE_SAMPLES + 1;
   localparam int IDXW  = $clog2(NBINS);
   localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [3:0] LAST_BIN = 4'(VOTE_SAMPLES);

   logic [COUNT_WIDTH-1:0] bins_ff [NBINS];
   logic [EXT_W-1:0]       rd_ext;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NBINS; i++) begin
         if (reset || clear) begin
            bins_ff[i] <= '0;
         end else if (vote.valid && vote.total == 4'(i) && !(&bins_ff[i])) begin
            bins_ff[i] <= bins_ff[i] + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      rd_ext = '0;
      if (rd_bin <= LAST_BIN) begin
         rd_ext = EXT_W'(bins_ff[rd_bin[IDXW-1:0]]);
      end
      rd_count = rd_ext[15:0];
   end

endmodule

`default_nettype wire

### hdl/ahs_sequencer.sv
`default_nettype none

module ahs_sequencer #(
   parameter int VOTE_SAMPLES = 10,
   parameter int COUNT_WIDTH  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire ahs_pkg::req_type item,
   input  wire ahs_pkg::cfg_type cfg,
   output ahs_pkg::vote_type     vote,
   output logic                  hist_clear,
   output ahs_pkg::rsp_type      status
);

   localparam logic [3:0] VOTE_N   = 4'(VOTE_SAMPLES);
   localparam logic [3:0] VOTE_MAJ = 4'(VOTE_SAMPLES / 2);
   localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   ahs_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             sidx_ff, sidx_in;
   logic [3:0]             votes_ff, votes_in;
   logic [15:0]            wait_ff, wait_in;
   logic [15:0]            hunt_ff, hunt_in;
   logic [COUNT_WIDTH-1:0] fast_ff, fast_in;
   logic [COUNT_WIDTH-1:0] back_ff, back_in;
   logic [COUNT_WIDTH-1:0] slow_ff, slow_in;
   logic                   ok_ff, ok_in;
   logic                   dir_ff, dir_in;

   logic                   pulse;
   logic                   reached;
   logic [3:0]             vt_sum;
   logic [3:0]             si_sum;
   logic [EXT_W-1:0]       fast_ext, back_ext, slow_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ahs_pkg::PH_IDLE;
         sidx_ff  <= '0;
         votes_ff <= '0;
         wait_ff  <= '0;
         hunt_ff  <= '0;
         fast_ff  <= '0;
         back_ff  <= '0;
         slow_ff  <= '0;
         ok_ff    <= 1'b1;
         dir_ff   <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         sidx_ff  <= sidx_in;
         votes_ff <= votes_in;
         wait_ff  <= wait_in;
         hunt_ff  <= hunt_in;
         fast_ff  <= fast_in;
         back_ff  <= back_in;
         slow_ff  <= slow_in;
         ok_ff    <= ok_in;
         dir_ff   <= dir_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      sidx_in    = sidx_ff;
      votes_in   = votes_ff;
      wait_in    = wait_ff;
      hunt_in    = hunt_ff;
      fast_in    = fast_ff;
      back_in    = back_ff;
      slow_in    = slow_ff;
      ok_in      = ok_ff;
      dir_in     = dir_ff;
      pulse      = 1'b0;
      vote       = '0;
      hist_clear = 1'b0;
      vt_sum     = votes_ff + {3'b000, item.switch_sample};
      si_sum     = sidx_ff + 4'd1;
      reached    = vt_sum > VOTE_MAJ;

      if (go) begin
         case (item.command)
            ahs_pkg::CMD_START: begin
               // restart the run from scratch
               phase_in   = ahs_pkg::PH_FAST;
               dir_in     = 1'b0;
               sidx_in    = '0;
               votes_in   = '0;
               wait_in    = '0;
               hunt_in    = '0;
               fast_in    = '0;
               back_in    = '0;
               slow_in    = '0;
               ok_in      = 1'b1;
               hist_clear = 1'b1;
            end
            ahs_pkg::CMD_TICK: begin
               if (phase_ff inside {ahs_pkg::PH_FAST, ahs_pkg::PH_BACK,
                                    ahs_pkg::PH_SLOW}) begin
                  if (wait_ff != '0) begin
                     // settle time after a step: drop the sample
                     wait_in = wait_ff - 16'd1;
                  end else if (si_sum < VOTE_N) begin
                     sidx_in  = si_sum;
                     votes_in = vt_sum;
                  end else begin
                     sidx_in    = '0;
                     votes_in   = '0;
                     vote.valid = 1'b1;
                     vote.total = vt_sum;
                     case (phase_ff)
                        ahs_pkg::PH_FAST: begin
                           if (reached) begin
                              phase_in = ahs_pkg::PH_BACK;
                              dir_in   = 1'b1;
                              hunt_in  = '0;
                           end else begin
                              dir_in  = 1'b0;
                              fast_in = sat_inc(fast_ff);
                              wait_in = cfg.fast_period;
                              pulse   = 1'b1;
                           end
                        end
                        ahs_pkg::PH_BACK: begin
                           if (!reached || hunt_ff == cfg.hunt_limit) begin
                              // a failed back-off still goes on to the slow approach
                              if (reached) begin
                                 ok_in = 1'b0;
                              end
                              phase_in = ahs_pkg::PH_SLOW;
                              dir_in   = 1'b0;
                              hunt_in  = '0;
                           end else begin
                              dir_in  = 1'b1;
                              back_in = sat_inc(back_ff);
                              hunt_in = hunt_ff + 16'd1;
                              wait_in = cfg.backoff_period;
                              pulse   = 1'b1;
                           end
                        end
                        default: begin
                           if (reached || hunt_ff == cfg.hunt_limit) begin
                              if (!reached) begin
                                 ok_in = 1'b0;
                              end
                              phase_in = ahs_pkg::PH_DONE;
                              dir_in   = 1'b1;
                           end else begin
                              dir_in  = 1'b0;
                              slow_in = sat_inc(slow_ff);
                              hunt_in = hunt_ff + 16'd1;
                              wait_in = cfg.slow_period;
                              pulse   = 1'b1;
                           end
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end

      fast_ext = EXT_W'(fast_in);
      back_ext = EXT_W'(back_in);
      slow_ext = EXT_W'(slow_in);

      status               = '0;
      status.step_pulse    = pulse;
      status.direction     = dir_in;
      status.phase         = 3'(phase_in);
      status.homed_ok      = ok_in;
      status.steps_fast    = fast_ext[15:0];
      status.steps_backoff = back_ext[15:0];
      status.steps_slow    = slow_ext[15:0];
   end

endmodule

`default_nettype wire

### hdl/axis_homing_sequencer_unit.sv
`default_nettype none

// Homing sequencer for one stepper axis. Each item is a tick carrying one
// limit-switch sample, a start command, or a histogram read, and each item
// yields exactly one result with the step pulse, direction, phase, ok flag,
// step counts and (on a read) the requested vote-histogram bin. The block
// takes one item per clock whenever rsp_stall is low: an item is latched in
// an input register, then decided combinationally by counter and compare
// logic into the result register, which drives the rsp_ port.
// req_stall rises only while both registers hold an item and rsp_stall is
// high. Configuration registers are to be written through the csr_ port only
// while no item is in flight; the block itself does not enforce this.
module axis_homing_sequencer_unit #(
   parameter int VOTE_SAMPLES = 10,
   parameter int COUNT_WIDTH  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ahs_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ahs_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   ahs_pkg::cfg_type  cfg_ff;
   logic              in_valid_ff, in_valid_in;
   ahs_pkg::req_type  in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   ahs_pkg::rsp_type  rsp_payload_ff, rsp_payload_in;

   logic              advance;
   logic              go;
   ahs_pkg::vote_type vote;
   logic              hist_clear;
   ahs_pkg::rsp_type  status;
   logic [15:0]       rd_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_period    <= ahs_pkg::FAST_PERIOD_RST;
         cfg_ff.backoff_period <= ahs_pkg::BACKOFF_PERIOD_RST;
         cfg_ff.slow_period    <= ahs_pkg::SLOW_PERIOD_RST;
         cfg_ff.hunt_limit     <= ahs_pkg::HUNT_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            ahs_pkg::CSR_FAST_PERIOD:    cfg_ff.fast_period    <= csr_wdata;
            ahs_pkg::CSR_BACKOFF_PERIOD: cfg_ff.backoff_period <= csr_wdata;
            ahs_pkg::CSR_SLOW_PERIOD:    cfg_ff.slow_period    <= csr_wdata;
            ahs_pkg::CSR_HUNT_LIMIT:     cfg_ff.hunt_limit     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // the result register moves when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = req_stall ? 1'b1 : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      rsp_payload_in = status;
      if (in_item_ff.command == ahs_pkg::CMD_READ) begin
         rsp_payload_in.bin_count = rd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_payload;
      end
      if (go) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   ahs_sequencer #(
      .VOTE_SAMPLES(VOTE_SAMPLES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .vote      (vote),
      .hist_clear(hist_clear),
      .status    (status)
   );

   ahs_histogram #(
      .VOTE_SAMPLES(VOTE_SAMPLES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_histogram (
      .clock   (clock),
      .reset   (reset),
      .clear   (hist_clear),
      .vote    (vote),
      .rd_bin  (in_item_ff.bin_index),
      .rd_count(rd_count)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### hdl/ahs_checker.sv
`default_nettype none

module ahs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ahs_pkg::rsp_type rsp_payload
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("held result changed");

   // input only backs up when the result side is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side free");

   // steps happen only in an active phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.step_pulse |->
         (rsp_payload.phase == ahs_pkg::PH_FAST ||
          rsp_payload.phase == ahs_pkg::PH_BACK ||
          rsp_payload.phase == ahs_pkg::PH_SLOW))
      else $error("step outside an active phase");

   // back-off steps go positive, approach steps go toward the switch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.step_pulse |->
         rsp_payload.direction == (rsp_payload.phase == ahs_pkg::PH_BACK))
      else $error("step in wrong direction");

   // before any run the counts are clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.phase == ahs_pkg::PH_IDLE |->
         rsp_payload.steps_fast == 16'd0 && rsp_payload.steps_backoff == 16'd0 &&
         rsp_payload.steps_slow == 16'd0 && rsp_payload.homed_ok &&
         rsp_payload.direction && rsp_payload.bin_count == 16'd0)
      else $error("idle status not clear");

endmodule

bind axis_homing_sequencer_unit ahs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

`default_nettype wire
